@@ hw/rtl/cefq_pkg.sv @@
`default_nettype none
package cefq_pkg;

  // Geometry and pixel format
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 8;
  localparam int NCH           = 3;
  localparam int PXW           = NCH * PIX_W;
  localparam int WIN           = 5;
  localparam int WIN_MID       = 2;
  localparam int NSLOT         = 4;
  localparam int SLOT_W        = $clog2(NSLOT);
  localparam int ROW_W         = 16;
  localparam int MIN_DIM       = 5;
  localparam int BORDER        = 2;
  localparam int PIX_MAX       = 255;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LEV_W      = 8;
  localparam int THR_W      = 9;
  localparam int FW_W       = 11;

  localparam logic [LEV_W-1:0] LEVELS_RST = 8'd8;
  localparam logic [THR_W-1:0] THRESH_RST = 9'd15;
  localparam logic [FW_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [ROW_W-1:0] HEIGHT_RST = 16'd480;

  // Quantizer divider: one quotient bit per step
  localparam int DIV_STEPS = PIX_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  typedef logic [2:0] wpos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS,
    CFG_THRESH,
    CFG_WIDTH,
    CFG_HEIGHT
  } cfg_idx_t;

  typedef struct packed {
    logic [LEV_W-1:0] levels;
    logic [THR_W-1:0] thresh;
    logic [FW_W-1:0]  width;
    logic [ROW_W-1:0] height;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_SEL,
    ST_STG1,
    ST_STG2,
    ST_STG3,
    ST_STG4,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_SHIFT,
    DP_SEL,
    DP_STG1,
    DP_STG2,
    DP_STG3,
    DP_STG4,
    DP_DIV,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    wpos_t  wr;
    wpos_t  wc;
    logic   last;
    logic   done;
  } dp_cmd_t;

  typedef struct packed {
    logic any;
    logic tail;
    logic last_row;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/cartoon_edge_quantize_filter_unit.sv @@
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_stall    in_blue_in, in_green_in, in_red_in
// out_      output     out_valid / out_stall  out_blue_out, out_green_out, out_red_out,
//                                             out_run_last, out_frame_done
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A pixel is accepted and shifted into the window, then each result it causes (n = 0..9)
// runs in turn through select, four arithmetic stages, 8 divider steps and emit.
// The quantizer's divider makes one quotient bit a step.
// Synchronous active-low reset clears control, position and window; line store is not cleared.
// Output stalls hold the last result in its register; the next one waits in emit.
`default_nettype none
module cartoon_edge_quantize_filter_unit #(
  parameter int MAX_WIDTH = cefq_pkg::MAX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [cefq_pkg::PIX_W-1:0]       in_blue_in,
  input  logic [cefq_pkg::PIX_W-1:0]       in_green_in,
  input  logic [cefq_pkg::PIX_W-1:0]       in_red_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [cefq_pkg::PIX_W-1:0]       out_blue_out,
  output logic [cefq_pkg::PIX_W-1:0]       out_green_out,
  output logic [cefq_pkg::PIX_W-1:0]       out_red_out,
  output logic                             out_run_last,
  output logic                             out_frame_done,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cefq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cefq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cefq_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  cefq_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cefq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  cefq_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg            (cfg),
    .in_blue_in     (in_blue_in),
    .in_green_in    (in_green_in),
    .in_red_in      (in_red_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blue_out   (out_blue_out),
    .out_green_out  (out_green_out),
    .out_red_out    (out_red_out),
    .out_run_last   (out_run_last),
    .out_frame_done (out_frame_done)
  );

endmodule
`default_nettype wire

@@ hw/rtl/cefq_cfg.sv @@
`default_nettype none
module cefq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cefq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cefq_pkg::CFG_DATA_W-1:0]  cfg_data,
  output cefq_pkg::cfg_t                   cfg
);
  import cefq_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = rst_n;
  assign cfg       = cfg_r;

  // Decode a register write request
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEVELS: cfg_nxt.levels = cfg_data[LEV_W-1:0];
        CFG_THRESH: cfg_nxt.thresh = cfg_data[THR_W-1:0];
        CFG_WIDTH:  cfg_nxt.width  = cfg_data[FW_W-1:0];
        CFG_HEIGHT: cfg_nxt.height = cfg_data[ROW_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.levels <= LEVELS_RST;
      cfg_r.thresh <= THRESH_RST;
      cfg_r.width  <= WIDTH_RST;
      cfg_r.height <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/cefq_ctrl.sv @@
`default_nettype none
module cefq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output cefq_pkg::dp_cmd_t   cmd,
  input  cefq_pkg::dp_stat_t  stat
);
  import cefq_pkg::*;

  state_t             state_r, state_nxt;
  wpos_t              wr_r, wr_nxt;
  wpos_t              wc_r, wc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  wpos_t              wr_end;
  logic               is_last;

  // Last result of this pixel: final column of the final window row
  assign wr_end  = stat.last_row ? wpos_t'(WIN - 1) : wpos_t'(WIN_MID);
  assign is_last = (wr_r == wr_end) &&
                   ((wc_r == wpos_t'(WIN - 1)) || ((wc_r == wpos_t'(WIN_MID)) && !stat.tail));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wr_r    <= wpos_t'(WIN_MID);
      wc_r    <= wpos_t'(WIN_MID);
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wr_r    <= wr_nxt;
      wc_r    <= wc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Sequence one request, then each of its results
  always_comb begin
    state_nxt = state_r;
    wr_nxt    = wr_r;
    wc_nxt    = wc_r;
    cnt_nxt   = cnt_r;
    in_stall  = (state_r != ST_IDLE) || !rst_n;
    cmd.op    = DP_NOP;
    cmd.wr    = wr_r;
    cmd.wc    = wc_r;
    cmd.last  = is_last;
    cmd.done  = is_last && stat.last_row && stat.tail;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd.op    = DP_ACCEPT;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        cmd.op = DP_SHIFT;
        if (stat.any) begin
          wr_nxt    = wpos_t'(WIN_MID);
          wc_nxt    = wpos_t'(WIN_MID);
          state_nxt = ST_SEL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SEL: begin
        cmd.op    = DP_SEL;
        state_nxt = ST_STG1;
      end
      ST_STG1: begin
        cmd.op    = DP_STG1;
        state_nxt = ST_STG2;
      end
      ST_STG2: begin
        cmd.op    = DP_STG2;
        state_nxt = ST_STG3;
      end
      ST_STG3: begin
        cmd.op    = DP_STG3;
        state_nxt = ST_STG4;
      end
      ST_STG4: begin
        cmd.op    = DP_STG4;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = DP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register frees up, then advance the window cursor
        if (stat.out_free) begin
          cmd.op = DP_OUT;
          if (is_last) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SEL;
            if ((wc_r == wpos_t'(WIN_MID)) && stat.tail) begin
              wc_nxt = wpos_t'(WIN_MID + 1);
            end else if (wc_r == wpos_t'(WIN_MID + 1)) begin
              wc_nxt = wpos_t'(WIN - 1);
            end else begin
              wr_nxt = wr_r + 1'b1;
              wc_nxt = wpos_t'(WIN_MID);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/cefq_dp.sv @@
`default_nettype none
module cefq_dp #(
  parameter int MAX_WIDTH = cefq_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  cefq_pkg::dp_cmd_t             cmd,
  output cefq_pkg::dp_stat_t            stat,
  input  cefq_pkg::cfg_t                cfg,
  input  logic [cefq_pkg::PIX_W-1:0]    in_blue_in,
  input  logic [cefq_pkg::PIX_W-1:0]    in_green_in,
  input  logic [cefq_pkg::PIX_W-1:0]    in_red_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cefq_pkg::PIX_W-1:0]    out_blue_out,
  output logic [cefq_pkg::PIX_W-1:0]    out_green_out,
  output logic [cefq_pkg::PIX_W-1:0]    out_red_out,
  output logic                          out_run_last,
  output logic                          out_frame_done
);
  import cefq_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CW     = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
  localparam int XW     = CW + 1;
  localparam int RW     = ROW_W + 1;
  localparam int VS_W   = PIX_W + 4;
  localparam int TS_W   = PIX_W + 2;
  localparam int SG_W   = PIX_W + 1;
  localparam int GS_W   = PIX_W + 3;
  localparam int SQ_W   = 2 * PIX_W;
  localparam int M2_W   = SQ_W + 1;
  localparam int TSQ_W  = 2 * THR_W + 1;
  localparam int D10_M  = 6554;
  localparam int D10_SH = 16;
  localparam int D10_W  = VS_W + 13;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [PXW-1:0]   pxl_t;

  // Truncating divide by ten through a reciprocal multiply (exact below 2560)
  function automatic pix_t div10(input logic [VS_W-1:0] x);
    logic [D10_W-1:0] p;
    begin
      p = D10_W'(x) * D10_W'(D10_M);
      return pix_t'(p >> D10_SH);
    end
  endfunction

  function automatic pix_t chan(input pxl_t p, input int ch);
    return p[ch*PIX_W +: PIX_W];
  endfunction

  // Bucket size per level count; zero levels acts as one
  pix_t bucket_tab [1 << LEV_W];
  for (genvar g = 0; g < (1 << LEV_W); g++) begin : g_bucket
    localparam int Bk = PIX_MAX / ((g == 0) ? 1 : g);
    assign bucket_tab[g] = pix_t'(Bk);
  end

  pix_t               bucket_r;
  logic [TSQ_W-1:0]   thr_sq_r;
  logic [THR_W:0]     thr_inc;

  // Magnitude exceeds the threshold exactly when its square reaches (thresh+1)^2
  assign thr_inc = {1'b0, cfg.thresh} + 1'b1;

  always_ff @(posedge clk) begin
    bucket_r <= bucket_tab[cfg.levels];
    thr_sq_r <= TSQ_W'(thr_inc * thr_inc);
  end

  // Geometry clamps
  logic [CW-1:0]    geo_w;
  logic [ROW_W-1:0] geo_h;

  always_comb begin
    geo_w = CW'(cfg.width);
    if (geo_w < CW'(MIN_DIM)) begin
      geo_w = CW'(MIN_DIM);
    end else if (geo_w > CW'(MAX_WIDTH)) begin
      geo_w = CW'(MAX_WIDTH);
    end
    geo_h = (cfg.height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : cfg.height;
  end

  // Raster position
  logic [CW-1:0]    col_r, col_nxt, cur_c_r;
  logic [ROW_W-1:0] row_r, row_nxt, cur_r_r;
  logic [CW-1:0]    c_eff;
  logic [ROW_W-1:0] r_eff;
  logic [RW-1:0]    r_tmp, r_tmp2;

  always_comb begin
    c_eff = col_r;
    r_tmp = {1'b0, row_r};
    if (col_r >= geo_w) begin
      c_eff = '0;
      r_tmp = r_tmp + 1'b1;
    end
    r_eff   = (r_tmp >= {1'b0, geo_h}) ? '0 : r_tmp[ROW_W-1:0];
    col_nxt = c_eff + 1'b1;
    row_nxt = r_eff;
    r_tmp2  = {1'b0, r_eff} + 1'b1;
    if (col_nxt >= geo_w) begin
      col_nxt = '0;
      row_nxt = (r_tmp2 >= {1'b0, geo_h}) ? '0 : r_tmp2[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cmd.op == DP_ACCEPT) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  pxl_t pix_in, pix_r;
  assign pix_in = {in_red_in, in_green_in, in_blue_in};

  always_ff @(posedge clk) begin
    if (cmd.op == DP_ACCEPT) begin
      pix_r   <= pix_in;
      cur_c_r <= c_eff;
      cur_r_r <= r_eff;
    end
  end

  // Line store: one bank per row slot, read old data while writing the new pixel
  pxl_t rd_r [NSLOT];
  for (genvar s = 0; s < NSLOT; s++) begin : g_bank
    pxl_t bank [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (cmd.op == DP_ACCEPT) begin
        rd_r[s] <= bank[c_eff[AW-1:0]];
        if (r_eff[SLOT_W-1:0] == SLOT_W'(s)) begin
          bank[c_eff[AW-1:0]] <= pix_in;
        end
      end
    end
  end

  // 5x5 window: shift left, fill the right column from the line store and the new pixel
  pxl_t win_r [WIN][WIN];
  pxl_t win_nxt [WIN][WIN];
  logic [SLOT_W-1:0] slot;

  always_comb begin
    slot = '0;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
    end
    for (int i = 0; i < WIN - 1; i++) begin
      slot = cur_r_r[SLOT_W-1:0] + SLOT_W'(i);
      win_nxt[i][WIN-1] = rd_r[slot];
    end
    win_nxt[WIN-1][WIN-1] = pix_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (cmd.op == DP_SHIFT) begin
      win_r <= win_nxt;
    end
  end

  // Plan for the controller
  assign stat.any      = (cur_r_r >= ROW_W'(BORDER)) && (cur_c_r >= CW'(BORDER));
  assign stat.tail     = (cur_c_r == geo_w - 1'b1);
  assign stat.last_row = (cur_r_r == geo_h - 1'b1);

  // Result select: gather the clamped neighborhood and border flags
  pxl_t            view_r [WIN][WIN];
  pxl_t            view_nxt [WIN][WIN];
  logic [3:0]      rs, cs;
  wpos_t           ri, ci;
  logic [RW-1:0]   yy;
  logic [XW-1:0]   xx;
  logic            vert_r, horz_r, ring_r;
  logic            vert_nxt, horz_nxt, ring_nxt;

  always_comb begin
    rs = '0;
    cs = '0;
    ri = '0;
    ci = '0;
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        rs = 4'(cmd.wr) + 4'(i) - 4'(WIN_MID);
        cs = 4'(cmd.wc) + 4'(j) - 4'(WIN_MID);
        ri = (rs > 4'(WIN - 1)) ? wpos_t'(WIN - 1) : rs[2:0];
        ci = (cs > 4'(WIN - 1)) ? wpos_t'(WIN - 1) : cs[2:0];
        view_nxt[i][j] = win_r[ri][ci];
      end
    end
    yy = RW'(cur_r_r) + RW'(cmd.wr) - RW'(WIN - 1);
    xx = XW'(cur_c_r) + XW'(cmd.wc) - XW'(WIN - 1);
    vert_nxt = (yy >= RW'(BORDER)) && (yy + RW'(BORDER + 1) <= RW'(geo_h));
    horz_nxt = (xx >= XW'(BORDER)) && (xx + XW'(BORDER + 1) <= XW'(geo_w));
    ring_nxt = (yy == '0) || (yy + 1'b1 == RW'(geo_h)) ||
               (xx == '0) || (xx + 1'b1 == XW'(geo_w));
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_SEL) begin
      view_r <= view_nxt;
      vert_r <= vert_nxt;
      horz_r <= horz_nxt;
      ring_r <= ring_nxt;
    end
  end

  // Stage 1: column sums for the blur, Sobel taps
  logic [VS_W-1:0]        vsum_r [NCH][WIN];
  logic [VS_W-1:0]        vsum_nxt [NCH][WIN];
  pix_t                   tx_r [NCH][3];
  pix_t                   tx_nxt [NCH][3];
  logic signed [SG_W-1:0] ty_r [NCH][3];
  logic signed [SG_W-1:0] ty_nxt [NCH][3];
  logic [TS_W-1:0]        tsum;

  always_comb begin
    tsum = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int j = 0; j < WIN; j++) begin
        vsum_nxt[ch][j] = VS_W'(chan(view_r[0][j], ch)) +
                          (VS_W'(chan(view_r[1][j], ch)) << 1) +
                          (VS_W'(chan(view_r[2][j], ch)) << 2) +
                          (VS_W'(chan(view_r[3][j], ch)) << 1) +
                          VS_W'(chan(view_r[4][j], ch));
      end
      for (int k = 0; k < 3; k++) begin
        tsum = TS_W'(chan(view_r[1][k+1], ch)) + (TS_W'(chan(view_r[2][k+1], ch)) << 1) +
               TS_W'(chan(view_r[3][k+1], ch));
        tx_nxt[ch][k] = tsum[TS_W-1:2];
        ty_nxt[ch][k] = $signed(SG_W'(chan(view_r[3][k+1], ch)) -
                                SG_W'(chan(view_r[1][k+1], ch)));
      end
    end
  end

  // Stage 2: vertical blur divide, gradients
  pix_t                   vb_r [NCH][WIN];
  pix_t                   vb_nxt [NCH][WIN];
  logic signed [SG_W-1:0] gx_r [NCH];
  logic signed [SG_W-1:0] gx_nxt [NCH];
  logic signed [SG_W-1:0] gy_r [NCH];
  logic signed [SG_W-1:0] gy_nxt [NCH];
  logic signed [GS_W-1:0] gs;

  always_comb begin
    gs = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      for (int j = 0; j < WIN; j++) begin
        vb_nxt[ch][j] = vert_r ? div10(vsum_r[ch][j]) : chan(view_r[WIN_MID][j], ch);
      end
      gx_nxt[ch] = $signed(SG_W'(tx_r[ch][2]) - SG_W'(tx_r[ch][0]));
      gs = {{2{ty_r[ch][0][SG_W-1]}}, ty_r[ch][0]} +
           {ty_r[ch][1][SG_W-1], ty_r[ch][1], 1'b0} +
           {{2{ty_r[ch][2][SG_W-1]}}, ty_r[ch][2]};
      // Divide by four rounding toward zero
      if (gs < 0) begin
        gs = gs + GS_W'(3);
      end
      gy_nxt[ch] = SG_W'(gs >>> 2);
    end
  end

  // Stage 3: horizontal blur sum, gradient squares
  logic [VS_W-1:0]          hsum_r [NCH];
  logic [VS_W-1:0]          hsum_nxt [NCH];
  logic [SQ_W-1:0]          sqx_r [NCH];
  logic [SQ_W-1:0]          sqx_nxt [NCH];
  logic [SQ_W-1:0]          sqy_r [NCH];
  logic [SQ_W-1:0]          sqy_nxt [NCH];
  logic signed [2*SG_W-1:0] px, py;

  always_comb begin
    px = '0;
    py = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      hsum_nxt[ch] = VS_W'(vb_r[ch][0]) + (VS_W'(vb_r[ch][1]) << 1) +
                     (VS_W'(vb_r[ch][2]) << 2) + (VS_W'(vb_r[ch][3]) << 1) +
                     VS_W'(vb_r[ch][4]);
      px = gx_r[ch] * gx_r[ch];
      py = gy_r[ch] * gy_r[ch];
      sqx_nxt[ch] = px[SQ_W-1:0];
      sqy_nxt[ch] = py[SQ_W-1:0];
    end
  end

  // Stage 4: blurred value, edge decision, divider load
  pix_t            v_r [NCH];
  pix_t            v_nxt [NCH];
  logic            edge_r, edge_nxt;
  logic [M2_W-1:0] mag2;
  logic [NCH-1:0]  hit;

  always_comb begin
    mag2 = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      v_nxt[ch] = horz_r ? div10(hsum_r[ch]) : vb_r[ch][WIN_MID];
      mag2      = M2_W'(sqx_r[ch]) + M2_W'(sqy_r[ch]);
      hit[ch]   = (TSQ_W'(mag2) >= thr_sq_r);
    end
    edge_nxt = !ring_r && (|hit);
  end

  // Restoring divider: remainder of value over bucket, one bit a step
  pix_t             sh_r [NCH];
  pix_t             sh_nxt [NCH];
  pix_t             rem_r [NCH];
  pix_t             rem_nxt [NCH];
  logic [PIX_W:0]   trial;

  always_comb begin
    trial = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      trial = {rem_r[ch], sh_r[ch][PIX_W-1]};
      if (trial >= {1'b0, bucket_r}) begin
        trial = trial - {1'b0, bucket_r};
      end
      rem_nxt[ch] = trial[PIX_W-1:0];
      sh_nxt[ch]  = sh_r[ch] << 1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_STG1: begin
        vsum_r <= vsum_nxt;
        tx_r   <= tx_nxt;
        ty_r   <= ty_nxt;
      end
      DP_STG2: begin
        vb_r <= vb_nxt;
        gx_r <= gx_nxt;
        gy_r <= gy_nxt;
      end
      DP_STG3: begin
        hsum_r <= hsum_nxt;
        sqx_r  <= sqx_nxt;
        sqy_r  <= sqy_nxt;
      end
      DP_STG4: begin
        v_r    <= v_nxt;
        sh_r   <= v_nxt;
        edge_r <= edge_nxt;
        for (int ch = 0; ch < NCH; ch++) begin
          rem_r[ch] <= '0;
        end
      end
      DP_DIV: begin
        sh_r  <= sh_nxt;
        rem_r <= rem_nxt;
      end
      default: begin
      end
    endcase
  end

  // Output register: quantized value is the value less its remainder, or zero on an edge
  logic  out_valid_r;
  pxl_t  out_pix_r, out_pix_nxt;
  logic  out_last_r, out_done_r;

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      out_pix_nxt[ch*PIX_W +: PIX_W] = edge_r ? '0 : (v_r[ch] - rem_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_OUT) begin
      out_pix_r  <= out_pix_nxt;
      out_last_r <= cmd.last;
      out_done_r <= cmd.done;
    end
  end

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_blue_out   = out_pix_r[0*PIX_W +: PIX_W];
  assign out_green_out  = out_pix_r[1*PIX_W +: PIX_W];
  assign out_red_out    = out_pix_r[2*PIX_W +: PIX_W];
  assign out_run_last   = out_last_r;
  assign out_frame_done = out_done_r;

endmodule
`default_nettype wire

@@ hw/rtl/cefq_checker.sv @@
`default_nettype none
module cefq_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_valid,
  input wire                             in_stall,
  input wire                             out_valid,
  input wire                             out_stall,
  input wire [cefq_pkg::PIX_W-1:0]       out_blue_out,
  input wire [cefq_pkg::PIX_W-1:0]       out_green_out,
  input wire [cefq_pkg::PIX_W-1:0]       out_red_out,
  input wire                             out_run_last,
  input wire                             out_frame_done
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // One pixel at a time: an accepted request blocks the next cycle
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // End of frame is always the last result of its pixel
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_run_last)
    else $error("frame end without run end");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_blue_out) && $stable(out_green_out) &&
    $stable(out_red_out) && $stable(out_run_last) && $stable(out_frame_done))
    else $error("stalled result changed");

endmodule

bind cartoon_edge_quantize_filter_unit cefq_checker u_chk (.*);
`default_nettype wire

@@ dv/tb_cartoon_edge_quantize_filter_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_cartoon_edge_quantize_filter_unit;
  import cefq_pkg::*;

  localparam int LINE_DEPTH = 1024;
  localparam int IDLE_WAIT  = 200;
  localparam int WDOG_LIMIT = 5000;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pixel_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
    logic       last;
    logic       done;
  } toon_px_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_blue_in = '0, in_green_in = '0, in_red_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_blue_out, out_green_out, out_red_out;
  logic out_run_last, out_frame_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cartoon_edge_quantize_filter_unit dut (.*);

  always #2 clk = ~clk;

  // Shadow copy of the filter state
  logic [23:0] line_mem [4*LINE_DEPTH];
  logic [23:0] win [25];
  int col_pos, row_pos;
  int lv_reg, thr_reg, fw_reg, fh_reg;

  pixel_t   pixel_q[$];
  toon_px_t toon_q[$];
  int err_cnt = 0;
  int in_gap = 0, out_hold = 0, idle_cycles = 0;
  logic cfg_seen = 1'b0;

  function automatic int tap(int wr, int wc, int ch);
    if (wr < 0) wr = 0;
    if (wr > 4) wr = 4;
    if (wc < 0) wc = 0;
    if (wc > 4) wc = 4;
    return int'((win[wr*5+wc] >> (8*ch)) & 24'hFF);
  endfunction

  function automatic int vsmooth(int wr, int wc, int ch, bit vert);
    if (!vert) return tap(wr, wc, ch);
    return (tap(wr-2, wc, ch) + 2*tap(wr-1, wc, ch) + 4*tap(wr, wc, ch)
            + 2*tap(wr+1, wc, ch) + tap(wr+2, wc, ch)) / 10;
  endfunction

  function automatic int root_floor(int n);
    int s = 0;
    while ((s+1)*(s+1) <= n) s++;
    return s;
  endfunction

  // Blur, quantize and edge-test one output pixel from the window
  function automatic toon_px_t toon_pixel(int y, int x, int wr, int wc, int w, int h);
    toon_px_t o;
    bit vert, horz, ring, is_edge;
    int lv, bucket, v, gx, gy, d;
    int q[3];
    int tx[3], ty[3];
    vert = (y >= 2) && (y <= h-3);
    horz = (x >= 2) && (x <= w-3);
    ring = (y == 0) || (y == h-1) || (x == 0) || (x == w-1);
    lv = (lv_reg == 0) ? 1 : lv_reg;
    bucket = 255 / lv;
    is_edge = 0;
    for (int ch = 0; ch < 3; ch++) begin
      if (horz)
        v = (vsmooth(wr, wc-2, ch, vert) + 2*vsmooth(wr, wc-1, ch, vert)
             + 4*vsmooth(wr, wc, ch, vert) + 2*vsmooth(wr, wc+1, ch, vert)
             + vsmooth(wr, wc+2, ch, vert)) / 10;
      else
        v = vsmooth(wr, wc, ch, vert);
      q[ch] = ((v / bucket) * bucket) & 255;
      if (!ring) begin
        for (d = -1; d <= 1; d++) begin
          tx[d+1] = (tap(wr-1, wc+d, ch) + 2*tap(wr, wc+d, ch) + tap(wr+1, wc+d, ch)) / 4;
          ty[d+1] = tap(wr+1, wc+d, ch) - tap(wr-1, wc+d, ch);
        end
        gx = tx[2] - tx[0];
        gy = (ty[0] + 2*ty[1] + ty[2]) / 4;
        if (root_floor(gx*gx + gy*gy) > thr_reg) is_edge = 1;
      end
    end
    o.b = is_edge ? 8'd0 : q[0][7:0];
    o.g = is_edge ? 8'd0 : q[1][7:0];
    o.r = is_edge ? 8'd0 : q[2][7:0];
    o.last = 1'b0;
    o.done = 1'b0;
    return o;
  endfunction

  // Advance the shadow state by one request and queue the pixels it releases
  function automatic void filter_request(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int w, h, c, rw, nx, ylo, yhi, n;
    int xs[3];
    toon_px_t res[9];
    w = fw_reg; h = fh_reg; c = col_pos; rw = row_pos; nx = 0; n = 0;
    if (w < 5) w = 5;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 5) h = 5;
    if (c >= w) begin c = 0; rw++; end
    if (rw >= h) rw = 0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) win[i*5+j] = win[i*5+j+1];
    for (int i = 0; i < 4; i++) win[i*5+4] = line_mem[((rw+i) & 3)*LINE_DEPTH + c];
    win[24] = {r, g, b};
    line_mem[(rw & 3)*LINE_DEPTH + c] = {r, g, b};
    if (rw >= 2) begin
      if (c >= 2) begin
        xs[nx] = c - 2;
        nx++;
      end
      if (c == w-1) begin
        xs[nx] = w - 2;
        nx++;
        xs[nx] = w - 1;
        nx++;
      end
      ylo = rw - 2;
      yhi = (rw == h-1) ? rw : rw - 2;
      for (int y = ylo; y <= yhi; y++)
        for (int k = 0; k < nx; k++) begin
          res[n] = toon_pixel(y, xs[k], y - rw + 4, xs[k] - c + 4, w, h);
          n++;
        end
      if (n > 0) begin
        res[n-1].last = 1'b1;
        if (rw == h-1 && c == w-1) res[n-1].done = 1'b1;
      end
      for (int k = 0; k < n; k++) toon_q.push_back(res[k]);
    end
    c++;
    if (c >= w) begin
      c = 0; rw++;
      if (rw >= h) rw = 0;
    end
    col_pos = c;
    row_pos = rw;
  endfunction

  function automatic int draw_gap();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
  endfunction

  // Driver: present queued pixels, predict on each accepted request
  always @(posedge clk) begin
    logic take;
    pixel_t p;
    take = in_valid && !in_stall;
    if (rst_n) begin
      if (take) begin
        filter_request(in_blue_in, in_green_in, in_red_in);
        in_gap = draw_gap();
      end
      if (!in_valid || take) begin
        if (in_gap == 0 && pixel_q.size() > 0) begin
          p = pixel_q.pop_front();
          in_blue_in  <= p.b;
          in_green_in <= p.g;
          in_red_in   <= p.r;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          if (in_gap > 0) in_gap--;
        end
      end
    end
  end

  // Monitor: random back-pressure, compare each accepted result
  always @(posedge clk) begin
    toon_px_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (toon_q.size() == 0) begin
          $error("unexpected result b=%0d g=%0d r=%0d", out_blue_out, out_green_out,
                 out_red_out);
          err_cnt++;
        end else begin
          e = toon_q.pop_front();
          if (out_blue_out !== e.b) begin
            $error("blue_out expected %0d got %0d", e.b, out_blue_out); err_cnt++;
          end
          if (out_green_out !== e.g) begin
            $error("green_out expected %0d got %0d", e.g, out_green_out); err_cnt++;
          end
          if (out_red_out !== e.r) begin
            $error("red_out expected %0d got %0d", e.r, out_red_out); err_cnt++;
          end
          if (out_run_last !== e.last) begin
            $error("run_last expected %0d got %0d", e.last, out_run_last); err_cnt++;
          end
          if (out_frame_done !== e.done) begin
            $error("frame_done expected %0d got %0d", e.done, out_frame_done); err_cnt++;
          end
        end
        out_hold = draw_gap();
      end
      if (out_hold > 0) begin
        out_stall <= 1'b1;
        out_hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("cartoon_edge_quantize_filter_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LEVELS: lv_reg  = val & 8'hFF;
      CFG_THRESH: thr_reg = val & 9'h1FF;
      CFG_WIDTH:  fw_reg  = val & 11'h7FF;
      CFG_HEIGHT: fh_reg  = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_frame(int lv, int thr, int w, int h);
    write_reg(CFG_LEVELS, lv);
    write_reg(CFG_THRESH, thr);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  // Hold until every request is consumed and every result checked
  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || toon_q.size() > 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  function automatic int clamp8(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Queue one frame of textured content: ramps, noise and hard steps
  function automatic int queue_frame();
    int w, h, mode, noise, slope;
    int base[3];
    pixel_t p;
    w = (fw_reg < 5) ? 5 : (fw_reg > LINE_DEPTH) ? LINE_DEPTH : fw_reg;
    h = (fh_reg < 5) ? 5 : fh_reg;
    mode = $urandom_range(0, 3);
    slope = $urandom_range(0, 12);
    for (int c = 0; c < 3; c++) base[c] = $urandom_range(0, 255);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) begin
        noise = $urandom_range(0, 6);
        case (mode)
          0: p = {8'($urandom), 8'($urandom), 8'($urandom)};
          1: p = {8'(clamp8(base[0] + slope*x - noise)), 8'(clamp8(base[1] + slope*y)),
                  8'(clamp8(base[2] - slope*(x+y) + noise))};
          2: p = (x > w/2) ? {8'(base[0]), 8'(base[1]), 8'(base[2])}
                           : {8'(base[2]), 8'(noise), 8'(base[0])};
          default: p = {8'(clamp8(base[0] + noise)), 8'(clamp8(base[1] - noise)),
                        8'(clamp8(base[2] + noise))};
        endcase
        pixel_q.push_back(p);
      end
    return w * h;
  endfunction

  initial begin
    int rand_items;
    pixel_t p;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0; row_pos = 0;
    lv_reg = 8; thr_reg = 15; fw_reg = 640; fh_reg = 480;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest frame with full-scale checkerboards and flat patches
    write_reg(CFG_HEIGHT, 65535);
    set_frame(8, 15, 5, 5);
    for (int k = 0; k < 25; k++) begin
      case (k % 5)
        0: p = '0;
        1: p = '1;
        2: p = ((k/5 + k) % 2) ? 24'hFFFFFF : 24'h000000;
        3: p = {8'h55, 8'hAA, 8'h0F};
        default: p = {8'hAA, 8'h55, 8'hF0};
      endcase
      pixel_q.push_back(p);
    end
    drain();

    // Corner settings: zero levels, zero and full threshold, clamped geometry
    set_frame(0, 0, 7, 6);    void'(queue_frame()); drain();
    set_frame(255, 511, 6, 5); void'(queue_frame()); drain();
    set_frame(1, 100, 0, 0);  void'(queue_frame()); drain();
    set_frame(17, 40, 9, 3);  void'(queue_frame()); drain();

    // Random frames with random settings
    rand_items = 0;
    while (rand_items < 310) begin
      set_frame($urandom_range(0, 255),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 60),
                $urandom_range(5, 12), $urandom_range(5, 9));
      rand_items += queue_frame();
      drain();
    end

    if (err_cnt == 0)
      $display("cartoon_edge_quantize_filter_unit test passed");
    else
      $display("cartoon_edge_quantize_filter_unit test failed");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/cefq_pkg.sv
hw/rtl/cefq_cfg.sv
hw/rtl/cefq_ctrl.sv
hw/rtl/cefq_dp.sv
hw/rtl/cartoon_edge_quantize_filter_unit.sv
hw/rtl/cefq_checker.sv
dv/tb_cartoon_edge_quantize_filter_unit.sv
